// File: rtl/core/wsfp_pkg.sv
// ----------------------------------------------------------------------------
// wsfp_pkg: shared types and constants of the sparse flow priority engine
// Holds the command, flow entry and result formats and the engine states.
// ----------------------------------------------------------------------------
package wsfp_pkg;

    localparam int FLOW_COUNT = 1024;
    localparam int FLOW_AW    = $clog2(FLOW_COUNT);

    localparam logic [15:0]        QUANTUM_RESET = 16'd1522;
    localparam logic [15:0]        COUNT_MAX     = 16'hffff;
    localparam logic [FLOW_AW-1:0] FLOW_LAST     = FLOW_AW'(FLOW_COUNT - 1);
    localparam logic [1:0]         QUEUE_FULL    = 2'd2;

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        CLS_DENSE       = 2'd0,
        CLS_NEW_SPARSE  = 2'd1,
        CLS_CONT_SPARSE = 2'd2
    } t_flow_class;

    typedef enum logic {
        ST_OK        = 1'b0,
        ST_EMPTY_DEQ = 1'b1
    } t_status;

    typedef enum logic [1:0] {
        ENG_CLEAR,
        ENG_FETCH,
        ENG_EXEC
    } t_eng_state;

    typedef struct packed {
        t_op                op;
        logic [FLOW_AW-1:0] idx;
        logic [15:0]        len;
        logic [31:0]        dprio;
    } t_cmd;

    typedef struct packed {
        logic [15:0] count;
        logic [31:0] bytes;
        logic [31:0] finish;
        logic [31:0] grace;
    } t_flow_entry;

    typedef struct packed {
        logic [31:0] prio;
        t_flow_class cls;
        logic [31:0] vt;
        logic [15:0] count;
        t_status     status;
    } t_result;

    // front to back: head of the command queue
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_front_out;

    // back to front: take the head, hold off new transactions
    typedef struct packed {
        logic pop;
        logic hold;
    } t_back_ctl;

endpackage

// File: rtl/core/wsfp_front.sv
// ----------------------------------------------------------------------------
// wsfp_front: input side of the priority engine
// Decodes each incoming transaction and holds it in a two-entry command queue.
// ----------------------------------------------------------------------------
module wsfp_front import wsfp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_opcode,
    input  logic [9:0]  i_flow_index,
    input  logic [15:0] i_packet_length,
    input  logic [31:0] i_dequeued_priority,
    input  t_back_ctl   i_back,
    output t_front_out  o_front
);

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;
    logic [1:0] n_count;
    t_cmd       w_cmd;
    logic       w_acc;
    logic       w_pop;

    // decode: opcode to operation, flow index folded onto the table
    always_comb begin
        w_cmd.op    = i_opcode ? OP_DEQ : OP_ENQ;
        w_cmd.idx   = i_flow_index[FLOW_AW-1:0];
        w_cmd.len   = i_packet_length;
        w_cmd.dprio = i_dequeued_priority;
    end

    assign full  = (r_count == QUEUE_FULL) || i_back.hold;
    assign w_acc = push && !full;
    assign w_pop = i_back.pop && (r_count != 2'd0);

    always_comb begin
        n_count = r_count;
        if (w_acc && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (w_pop && !w_acc) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_acc) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    assign o_front.valid = (r_count != 2'd0);
    assign o_front.cmd   = r_q[r_rp];

endmodule

// File: rtl/core/wsfp_engine.sv
// ----------------------------------------------------------------------------
// wsfp_engine: flow table read-modify-write and result queue
// Clears the flow table after reset, then runs one command at a time, fetch then exec.
// ----------------------------------------------------------------------------
module wsfp_engine import wsfp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  t_front_out  i_front,
    output t_back_ctl   o_back,
    input  logic        pop,
    output logic        o_res_valid,
    output t_result     o_res
);

    t_flow_entry        r_mem [FLOW_COUNT];
    t_flow_entry        r_rd;
    t_cmd               r_cmd;
    t_eng_state         r_state;
    t_eng_state         n_state;
    logic [FLOW_AW-1:0] r_clr_addr;
    logic [15:0]        r_quantum;
    logic [31:0]        r_vt;
    logic [31:0]        n_vt;

    t_result            r_out [2];
    logic               r_out_wp;
    logic               r_out_rp;
    logic [1:0]         r_out_count;
    logic               w_out_pop;
    logic               w_exec;

    t_flow_entry        w_entry;
    t_result            w_res;
    logic [31:0]        w_q32;
    logic [31:0]        w_len32;
    logic [31:0]        w_start;
    logic [31:0]        w_fin_base;
    logic [31:0]        w_prio;
    logic               w_new;
    logic               w_cont;

    // sequencer
    always_comb begin
        n_state     = r_state;
        o_back.pop  = 1'b0;
        o_back.hold = 1'b0;
        w_exec      = 1'b0;
        case (r_state)
            ENG_CLEAR: begin
                o_back.hold = 1'b1;
                if (r_clr_addr == FLOW_LAST) begin
                    n_state = ENG_FETCH;
                end
            end
            ENG_FETCH: begin
                // start only with a free result slot for this command
                if (i_front.valid && (r_out_count != QUEUE_FULL)) begin
                    o_back.pop = 1'b1;
                    n_state    = ENG_EXEC;
                end
            end
            ENG_EXEC: begin
                w_exec  = 1'b1;
                n_state = ENG_FETCH;
            end
            default: begin
                n_state = ENG_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ENG_CLEAR;
            r_clr_addr <= '0;
            r_quantum  <= QUANTUM_RESET;
            r_vt       <= {16'd0, QUANTUM_RESET};
        end else begin
            r_state <= n_state;
            if (r_state == ENG_CLEAR) begin
                r_clr_addr <= r_clr_addr + FLOW_AW'(1);
            end
            if (i_cfg_we) begin
                r_quantum <= i_cfg_wdata;
            end
            if (w_exec) begin
                r_vt <= n_vt;
            end
        end
    end

    // flow table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_state == ENG_CLEAR) begin
            r_mem[r_clr_addr] <= '0;
        end else if (w_exec) begin
            r_mem[r_cmd.idx] <= w_entry;
        end
        if (o_back.pop) begin
            r_rd  <= r_mem[i_front.cmd.idx];
            r_cmd <= i_front.cmd;
        end
    end

    // update of one flow entry
    always_comb begin
        w_q32      = {16'd0, r_quantum};
        w_len32    = {16'd0, r_cmd.len};
        w_new      = (r_rd.count == 16'd0) && (r_vt >= r_rd.grace);
        w_cont     = !w_new && (r_rd.bytes < w_q32);
        w_start    = (w_new || w_cont) ? (r_vt - w_q32) : r_vt;
        w_fin_base = w_new ? 32'd0 : r_rd.finish;
        w_prio     = (w_start > w_fin_base) ? w_start : w_fin_base;

        w_entry    = r_rd;
        n_vt       = r_vt;
        w_res.prio   = 32'd0;
        w_res.cls    = CLS_DENSE;
        w_res.status = ST_OK;

        case (r_cmd.op)
            OP_ENQ: begin
                if (w_new) begin
                    w_entry.bytes = w_len32;
                    w_entry.grace = r_vt + w_q32;
                    w_res.cls     = CLS_NEW_SPARSE;
                end else if (w_cont) begin
                    w_entry.bytes = r_rd.bytes + w_len32;
                    w_res.cls     = CLS_CONT_SPARSE;
                end
                if (r_rd.count != COUNT_MAX) begin
                    w_entry.count = r_rd.count + 16'd1;
                end
                w_entry.finish = w_prio + w_len32;
                w_res.prio     = w_prio;
            end
            OP_DEQ: begin
                // empty flow: keep the count at zero and flag it
                if (r_rd.count == 16'd0) begin
                    w_res.status = ST_EMPTY_DEQ;
                end else begin
                    w_entry.count = r_rd.count - 16'd1;
                end
                if (r_cmd.dprio > r_vt) begin
                    n_vt = r_cmd.dprio;
                end
            end
            default: begin
                w_entry = r_rd;
            end
        endcase

        w_res.vt    = n_vt;
        w_res.count = w_entry.count;
    end

    // result queue
    assign w_out_pop = pop && (r_out_count != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_wp    <= 1'b0;
            r_out_rp    <= 1'b0;
            r_out_count <= 2'd0;
        end else begin
            if (w_exec) begin
                r_out_wp <= ~r_out_wp;
            end
            if (w_out_pop) begin
                r_out_rp <= ~r_out_rp;
            end
            if (w_exec && !w_out_pop) begin
                r_out_count <= r_out_count + 2'd1;
            end else if (w_out_pop && !w_exec) begin
                r_out_count <= r_out_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_out[r_out_wp] <= w_res;
        end
    end

    assign o_res_valid = (r_out_count != 2'd0);
    assign o_res       = r_out[r_out_rp];

endmodule

// File: rtl/core/wfq_sparse_flow_priority.sv
// ----------------------------------------------------------------------------
// wfq_sparse_flow_priority: fair queueing priority with sparse flow boost
// Computes the start-time fair queueing priority of each enqueued packet and
// tracks virtual time and per-flow state across enqueues and dequeues.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel is queue-like: drive push with the opcode, flow index,
//   packet length and dequeued priority; a transaction is taken at a clock
//   edge where push is high and full is low.
//   Result channel is queue-like too: while empty is low the oldest result
//   is on the o_ ports; pop with empty low takes it. One result per input.
//   Quantum register: i_cfg_we with i_cfg_wdata, write only while idle.
// Sequence:
//   Each transaction reads the flow table in the fetch state and updates
//   it in the exec state; a new transaction is taken from the command queue
//   only after the last one is updated. A result passes the command queue,
//   the registered flow table read and the result queue before it shows.
// Reset:
//   i_rst_n is synchronous, active low. After reset the flow table is swept
//   to zero, one entry per cycle, all 1024 entries; full stays high meanwhile.
//   Virtual time and quantum restart at 1522.
// Stall:
//   Two results can wait at the output. When they are not popped, the
//   engine holds, the two-entry command queue fills and full rises.
// ----------------------------------------------------------------------------
module wfq_sparse_flow_priority import wsfp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        push,
    output logic        full,
    input  logic        i_opcode,
    input  logic [9:0]  i_flow_index,
    input  logic [15:0] i_packet_length,
    input  logic [31:0] i_dequeued_priority,
    // configuration
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    // result channel
    input  logic        pop,
    output logic        empty,
    output logic [31:0] o_priority_res,
    output logic [1:0]  o_flow_class,
    output logic [31:0] o_virtual_time_out,
    output logic [15:0] o_queued_packets,
    output logic        o_status
);

    t_front_out w_front;
    t_back_ctl  w_back;
    t_result    w_res;
    logic       w_res_valid;

    // front: decode and buffer incoming transactions
    wsfp_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .push                (push),
        .full                (full),
        .i_opcode            (i_opcode),
        .i_flow_index        (i_flow_index),
        .i_packet_length     (i_packet_length),
        .i_dequeued_priority (i_dequeued_priority),
        .i_back              (w_back),
        .o_front             (w_front)
    );

    // back: flow table update and result buffering
    wsfp_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_front     (w_front),
        .o_back      (w_back),
        .pop         (pop),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    assign empty              = !w_res_valid;
    assign o_priority_res     = w_res.prio;
    assign o_flow_class       = w_res.cls;
    assign o_virtual_time_out = w_res.vt;
    assign o_queued_packets   = w_res.count;
    assign o_status           = w_res.status;

endmodule

// File: rtl/core/wsfp_checker.sv
// ----------------------------------------------------------------------------
// wsfp_checker: port-level checks of the sparse flow priority engine
// Watches reset behavior and the consistency of each shown result.
// ----------------------------------------------------------------------------
module wsfp_checker import wsfp_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic [31:0] o_priority_res,
    input logic [1:0]  o_flow_class,
    input logic [15:0] o_queued_packets,
    input logic        o_status
);

    // reset drops any waiting result
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result shown right after reset");

    // the table sweep follows reset, so no transaction is taken
    a_reset_full: assert property (@(posedge i_clk)
        !i_rst_n |=> full)
        else $error("input open right after reset");

    // a flagged dequeue reports no priority, dense class, zero count
    a_status_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status) |->
            (o_priority_res == 32'd0) && (o_flow_class == CLS_DENSE)
            && (o_queued_packets == 16'd0))
        else $error("inconsistent fields on empty-flow dequeue");

    // a sparse enqueue always leaves at least one packet queued
    a_enq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && ((o_flow_class == CLS_NEW_SPARSE)
            || (o_flow_class == CLS_CONT_SPARSE))) |->
            (o_queued_packets != 16'd0) && !o_status)
        else $error("sparse result with zero queued packets");

endmodule

bind wfq_sparse_flow_priority wsfp_checker u_wsfp_checker (.*);
